FILE: hw/rtl/mi3_pkg.sv
// shared constants for the 3x3 matrix inverse block
package mi3_pkg;

   localparam int ELEM_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int NUM_ENTRIES        = 9;

endpackage

FILE: hw/rtl/matrix_inverse_3x3.sv
// 3x3 fixed-point matrix inverse by adjugate and determinant, fully pipelined
//
// usage:
//   a word (nine signed Q entries, row-major) is taken at a rising edge with
//   start high and busy low. busy is only high during reset, so a new matrix
//   can be started every cycle
//   results leave on the rsp_ ports for one cycle, marked by rsp_valid:
//   nine inverse entries, the determinant and the singular flag
//   rsp_valid is the accepting valid bit carried down the whole pipeline, and
//   throughput is one matrix per cycle
//   the depth is set by the divider pipelines: nine of them, an overflow check then
//   one quotient bit per stage, plus seven stages ahead of them and an output stage
//   reset is synchronous and clears the valid bits; words in flight are dropped
//   the receiver cannot stall, so nothing holds the pipeline; a singular matrix
//   gives rsp_singular high with all inverse entries and determinant zero
module matrix_inverse_3x3
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r1c1,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r1c2,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r1c3,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r2c1,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r2c2,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r2c3,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r3c1,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r3c2,
   input  logic signed [ELEM_WIDTH-1:0] req_in_r3c3,
   output logic                         rsp_valid,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r1c1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r1c2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r1c3,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r2c1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r2c2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r2c3,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r3c1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r3c2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_r3c3,
   output logic signed [ELEM_WIDTH-1:0] rsp_determinant,
   output logic                         rsp_singular
);

   localparam int W    = ELEM_WIDTH;
   localparam int N    = NUM_ENTRIES;
   localparam int PW   = 2*W;        // element product
   localparam int CW   = 2*W + 1;    // cofactor, signed
   localparam int DETW = 3*W + 2;    // determinant, signed
   localparam int DMW  = 3*W + 1;    // determinant magnitude
   localparam int SHW  = DMW - 2*FRAC_BITS;

   // adjugate entry i = m[PX]*m[PY] - m[QX]*m[QY], row-major over the inverse
   localparam int PX [N] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int PY [N] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int QX [N] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int QY [N] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------- stage 1: input registers
   logic              v1_ff;
   logic signed [W-1:0] m1_ff [N];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
   end

   always_ff @(posedge clock) begin
      m1_ff[0] <= req_in_r1c1;
      m1_ff[1] <= req_in_r1c2;
      m1_ff[2] <= req_in_r1c3;
      m1_ff[3] <= req_in_r2c1;
      m1_ff[4] <= req_in_r2c2;
      m1_ff[5] <= req_in_r2c3;
      m1_ff[6] <= req_in_r3c1;
      m1_ff[7] <= req_in_r3c2;
      m1_ff[8] <= req_in_r3c3;
   end

   // ---------------- stage 2: the eighteen element products
   logic                 v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [PW-1:0] p2_ff [N];
   logic signed [PW-1:0] q2_ff [N];
   logic signed [W-1:0]  m2_ff [3];
   logic signed [W-1:0]  m3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_prod
      always_ff @(posedge clock) begin
         p2_ff[i] <= PW'(m1_ff[PX[i]]) * PW'(m1_ff[PY[i]]);
         q2_ff[i] <= PW'(m1_ff[QX[i]]) * PW'(m1_ff[QY[i]]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         m2_ff[j] <= m1_ff[j];
         m3_ff[j] <= m2_ff[j];
      end
   end

   // ---------------- stage 3: cofactors
   logic signed [CW-1:0] ad3_ff [N];
   logic signed [CW-1:0] ad4_ff [N];
   logic signed [CW-1:0] ad5_ff [N];
   logic signed [CW-1:0] ad6_ff [N];

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         ad3_ff[i] <= CW'(p2_ff[i]) - CW'(q2_ff[i]);
         ad4_ff[i] <= ad3_ff[i];
         ad5_ff[i] <= ad4_ff[i];
         ad6_ff[i] <= ad5_ff[i];
      end
   end

   // ---------------- stage 4: first-row expansion, split into low and high halves
   // det = m0*ad0 + m1*ad3 + m2*ad6 (first row times first adjugate column)
   logic signed [PW:0]   plo4_ff [3];
   logic signed [PW:0]   phi4_ff [3];
   logic signed [DETW-1:0] t5_ff  [3];
   logic signed [DETW-1:0] det6_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         plo4_ff[j] <= (PW+1)'(m3_ff[j]) * $signed({1'b0, ad3_ff[3*j][W-1:0]});
         phi4_ff[j] <= (PW+1)'(m3_ff[j]) * (PW+1)'($signed(ad3_ff[3*j][CW-1:W]));
      end
   end

   // ---------------- stage 5: recombine halves
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         t5_ff[j] <= (DETW'(phi4_ff[j]) <<< W) + DETW'(plo4_ff[j]);
      end
   end

   // ---------------- stage 6: determinant
   always_ff @(posedge clock) begin
      det6_ff <= t5_ff[0] + t5_ff[1] + t5_ff[2];
   end

   // ---------------- stage 7: magnitudes and signs for the dividers
   logic                 det_neg;
   logic [DETW-1:0]      det_abs;
   logic [DMW-1:0]       den7_ff;
   logic                 sing7_ff;
   logic [PW-1:0]        mag7_ff [N];
   logic                 neg7_ff [N];

   assign det_neg = det6_ff[DETW-1];
   assign det_abs = det_neg ? DETW'(-det6_ff) : DETW'(det6_ff);

   always_ff @(posedge clock) begin
      den7_ff  <= det_abs[DMW-1:0];
      sing7_ff <= (det6_ff == '0);
      for (int i = 0; i < N; i++) begin
         mag7_ff[i] <= ad6_ff[i][CW-1] ? PW'(-ad6_ff[i]) : PW'(ad6_ff[i]);
         neg7_ff[i] <= ad6_ff[i][CW-1] ^ det_neg;
      end
   end

   // determinant output: magnitude shifted down and saturated, sign carried beside
   logic [SHW-1:0] det_sh;
   logic [W-1:0]   det_lim;
   logic [W-1:0]   det_mag;
   logic           det7_neg_ff;

   always_ff @(posedge clock) begin
      det7_neg_ff <= det_neg;
   end

   assign det_sh  = den7_ff[DMW-1:2*FRAC_BITS];
   assign det_lim = det7_neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   assign det_mag = (det_sh > SHW'(det_lim)) ? det_lim : det_sh[W-1:0];

   // ---------------- divider pipelines, W+1 stages each
   logic [W-1:0] quot [N];
   logic         ovf  [N];
   logic         qneg [N];

   for (genvar i = 0; i < N; i++) begin : g_div
      mi3_div #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .num_mag (mag7_ff[i]),
         .den     (den7_ff),
         .neg     (neg7_ff[i]),
         .quot    (quot[i]),
         .ovf     (ovf[i]),
         .neg_out (qneg[i])
      );
   end

   // sideband running beside the dividers
   logic         sbv_ff   [W+1];
   logic         sbs_ff   [W+1];
   logic [W-1:0] sbd_ff   [W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= W; s++) sbv_ff[s] <= 1'b0;
      end else begin
         sbv_ff[0] <= v7_ff;
         for (int s = 1; s <= W; s++) sbv_ff[s] <= sbv_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      sbs_ff[0] <= sing7_ff;
      sbd_ff[0] <= sing7_ff ? '0 : (det7_neg_ff ? W'(-det_mag) : det_mag);
      for (int s = 1; s <= W; s++) begin
         sbs_ff[s] <= sbs_ff[s-1];
         sbd_ff[s] <= sbd_ff[s-1];
      end
   end

   // ---------------- output stage: saturate, apply sign, zero on singular
   logic [W-1:0] inv_in [N];
   logic [W-1:0] inv_ff [N];
   logic         rsp_valid_ff;
   logic         sing_ff;
   logic [W-1:0] det_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         logic [W-1:0] lim;
         logic [W-1:0] mag;
         lim = qneg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         mag = (ovf[i] || (quot[i] > lim)) ? lim : quot[i];
         if (sbs_ff[W]) inv_in[i] = '0;
         else           inv_in[i] = qneg[i] ? W'(-mag) : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= sbv_ff[W];
   end

   always_ff @(posedge clock) begin
      sing_ff <= sbs_ff[W];
      det_ff  <= sbd_ff[W];
      for (int i = 0; i < N; i++) inv_ff[i] <= inv_in[i];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_determinant = $signed(det_ff);
   assign rsp_inv_r1c1    = $signed(inv_ff[0]);
   assign rsp_inv_r1c2    = $signed(inv_ff[1]);
   assign rsp_inv_r1c3    = $signed(inv_ff[2]);
   assign rsp_inv_r2c1    = $signed(inv_ff[3]);
   assign rsp_inv_r2c2    = $signed(inv_ff[4]);
   assign rsp_inv_r2c3    = $signed(inv_ff[5]);
   assign rsp_inv_r3c1    = $signed(inv_ff[6]);
   assign rsp_inv_r3c2    = $signed(inv_ff[7]);
   assign rsp_inv_r3c3    = $signed(inv_ff[8]);

endmodule

FILE: hw/rtl/mi3_div.sv
// pipelined restoring divider, one quotient bit per stage, flags quotient width overflow
module mi3_div
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic [2*ELEM_WIDTH-1:0]   num_mag,
   input  logic [3*ELEM_WIDTH:0]     den,
   input  logic                      neg,
   output logic [ELEM_WIDTH-1:0]     quot,
   output logic                      ovf,
   output logic                      neg_out
);

   localparam int W   = ELEM_WIDTH;
   localparam int NW  = 2*W + 2*FRAC_BITS;
   localparam int HW  = NW - W;
   localparam int DMW = 3*W + 1;
   localparam int XW  = (HW > DMW) ? HW : DMW;

   logic [NW-1:0]  num;
   logic [XW-1:0]  hi_ext;
   logic [XW-1:0]  den_ext;

   logic [DMW-1:0] rem_ff [W+1];
   logic [W-1:0]   lo_ff  [W+1];
   logic [W-1:0]   q_ff   [W+1];
   logic [DMW-1:0] den_ff [W+1];
   logic           ovf_ff [W+1];
   logic           neg_ff [W+1];

   assign num     = {num_mag, {(2*FRAC_BITS){1'b0}}};
   assign hi_ext  = XW'(num[NW-1:W]);
   assign den_ext = XW'(den);

   // first stage: quotient overflow check, top part is the starting remainder
   always_ff @(posedge clock) begin
      rem_ff[0] <= hi_ext[DMW-1:0];
      lo_ff[0]  <= num[W-1:0];
      q_ff[0]   <= '0;
      den_ff[0] <= den;
      ovf_ff[0] <= (hi_ext >= den_ext);
      neg_ff[0] <= neg;
   end

   for (genvar s = 1; s <= W; s++) begin : g_stage
      logic [DMW:0] trial;
      logic         ge;
      assign trial = {rem_ff[s-1], lo_ff[s-1][W-1]};
      assign ge    = (trial >= {1'b0, den_ff[s-1]});
      always_ff @(posedge clock) begin
         rem_ff[s] <= ge ? DMW'(trial - {1'b0, den_ff[s-1]}) : trial[DMW-1:0];
         lo_ff[s]  <= {lo_ff[s-1][W-2:0], 1'b0};
         q_ff[s]   <= {q_ff[s-1][W-2:0], ge};
         den_ff[s] <= den_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
      end
   end

   assign quot    = q_ff[W];
   assign ovf     = ovf_ff[W];
   assign neg_out = neg_ff[W];

endmodule

FILE: hw/rtl/mi3_checker.sv
// port-level checks for the 3x3 matrix inverse, bound to the top level
module mi3_checker
   import mi3_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic                  rsp_singular,
   input logic [ELEM_WIDTH-1:0] rsp_determinant,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r1c1,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r1c2,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r1c3,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r2c1,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r2c2,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r2c3,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r3c1,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r3c2,
   input logic [ELEM_WIDTH-1:0] rsp_inv_r3c3
);

   // edges from the accepting edge to the edge that takes the result
   localparam int LATENCY = ELEM_WIDTH + 9;

   // pipeline never pushes back outside reset
   a_no_busy: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy high outside reset");

   // every result traces back to a word taken a fixed time earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching start");

   // singular results carry all-zero payload
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |->
         (rsp_determinant == '0) && (rsp_inv_r1c1 == '0) && (rsp_inv_r1c2 == '0) &&
         (rsp_inv_r1c3 == '0) && (rsp_inv_r2c1 == '0) && (rsp_inv_r2c2 == '0) &&
         (rsp_inv_r2c3 == '0) && (rsp_inv_r3c1 == '0) && (rsp_inv_r3c2 == '0) &&
         (rsp_inv_r3c3 == '0))
      else $error("singular result with nonzero payload");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_singular    (rsp_singular),
   .rsp_determinant (rsp_determinant),
   .rsp_inv_r1c1    (rsp_inv_r1c1),
   .rsp_inv_r1c2    (rsp_inv_r1c2),
   .rsp_inv_r1c3    (rsp_inv_r1c3),
   .rsp_inv_r2c1    (rsp_inv_r2c1),
   .rsp_inv_r2c2    (rsp_inv_r2c2),
   .rsp_inv_r2c3    (rsp_inv_r2c3),
   .rsp_inv_r3c1    (rsp_inv_r3c1),
   .rsp_inv_r3c2    (rsp_inv_r3c2),
   .rsp_inv_r3c3    (rsp_inv_r3c3)
);

FILE: tb/sv/testbench.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse block
`timescale 1ns / 100ps

module testbench
   import mi3_pkg::*;
();

   localparam int EW        = ELEM_WIDTH_DEFAULT;
   localparam int FB        = FRAC_BITS_DEFAULT;
   localparam int LATENCY   = EW + 8;
   localparam int CYC_LIMIT = 200000;
   localparam int N_RANDOM  = 540;
   localparam logic signed [EW-1:0] ONE  = 1 <<< FB;
   localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [159:0] wide_type;

   // one matrix word, row-major
   typedef struct {
      elem_type e[NUM_ENTRIES];
   } matrix_type;

   // one result word
   typedef struct {
      elem_type inv[NUM_ENTRIES];
      elem_type det;
      logic     singular;
   } inverse_type;

   // directed stimulus row; expected typed in only where obvious
   typedef struct {
      matrix_type  mat;
      bit          typed;
      inverse_type want;
   } vector_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     start = 1'b0;
   logic     busy;
   elem_type req_in[NUM_ENTRIES];
   logic     rsp_valid;
   elem_type rsp_inv[NUM_ENTRIES];
   elem_type rsp_determinant;
   logic     rsp_singular;

   inverse_type pending_inverses[$];
   inverse_type typed_answers[$];   // aligned with words: typed answer or none
   bit          typed_flags[$];
   int          words_accepted = 0;
   int          words_checked  = 0;
   int          singular_seen  = 0;
   int          mismatches     = 0;
   int          cycles         = 0;
   int          send_gap_pct   = 0;

   initial for (int i = 0; i < NUM_ENTRIES; i++) req_in[i] = '0;

   matrix_inverse_3x3 DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_in_r1c1    (req_in[0]),
      .req_in_r1c2    (req_in[1]),
      .req_in_r1c3    (req_in[2]),
      .req_in_r2c1    (req_in[3]),
      .req_in_r2c2    (req_in[4]),
      .req_in_r2c3    (req_in[5]),
      .req_in_r3c1    (req_in[6]),
      .req_in_r3c2    (req_in[7]),
      .req_in_r3c3    (req_in[8]),
      .rsp_valid      (rsp_valid),
      .rsp_inv_r1c1   (rsp_inv[0]),
      .rsp_inv_r1c2   (rsp_inv[1]),
      .rsp_inv_r1c3   (rsp_inv[2]),
      .rsp_inv_r2c1   (rsp_inv[3]),
      .rsp_inv_r2c2   (rsp_inv[4]),
      .rsp_inv_r2c3   (rsp_inv[5]),
      .rsp_inv_r3c1   (rsp_inv[6]),
      .rsp_inv_r3c2   (rsp_inv[7]),
      .rsp_inv_r3c3   (rsp_inv[8]),
      .rsp_determinant(rsp_determinant),
      .rsp_singular   (rsp_singular)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // clamp a magnitude to the signed element range and apply the sign
   function automatic elem_type clamp_signed(logic [159:0] mag, bit neg);
      logic [159:0] lim;
      lim = neg ? (160'd1 << (EW - 1)) : ((160'd1 << (EW - 1)) - 1);
      if (mag > lim) mag = lim;
      return neg ? elem_type'(-mag) : elem_type'(mag);
   endfunction

   // exact adjugate over determinant, truncated toward zero
   function automatic inverse_type invert_matrix(matrix_type a);
      wide_type     m[NUM_ENTRIES];
      wide_type     adj[NUM_ENTRIES];
      wide_type     d;
      logic [159:0] num, den;
      inverse_type  r;
      for (int i = 0; i < NUM_ENTRIES; i++) m[i] = wide_type'(a.e[i]);
      // adj[r*3+c] is the cofactor of entry (c,r)
      adj[0] =   m[4] * m[8] - m[5] * m[7];
      adj[3] = -(m[3] * m[8] - m[5] * m[6]);
      adj[6] =   m[3] * m[7] - m[4] * m[6];
      adj[1] = -(m[1] * m[8] - m[2] * m[7]);
      adj[4] =   m[0] * m[8] - m[2] * m[6];
      adj[7] = -(m[0] * m[7] - m[1] * m[6]);
      adj[2] =   m[1] * m[5] - m[2] * m[4];
      adj[5] = -(m[0] * m[5] - m[2] * m[3]);
      adj[8] =   m[0] * m[4] - m[1] * m[3];
      // expansion along the first row
      d = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
      if (d == 0) begin
         foreach (r.inv[i]) r.inv[i] = '0;
         r.det      = '0;
         r.singular = 1'b1;
         return r;
      end
      den = (d < 0) ? -d : d;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         num = (adj[i] < 0) ? -adj[i] : adj[i];
         num = num << (2 * FB);
         r.inv[i] = clamp_signed(num / den, (adj[i] < 0) != (d < 0));
      end
      r.det      = clamp_signed(den >> (2 * FB), d < 0);
      r.singular = 1'b0;
      return r;
   endfunction

   function automatic matrix_type diag_matrix(elem_type v);
      matrix_type m;
      foreach (m.e[i]) m.e[i] = (i % 4 == 0) ? v : '0;
      return m;
   endfunction

   function automatic matrix_type fill_matrix(elem_type v);
      matrix_type m;
      foreach (m.e[i]) m.e[i] = v;
      return m;
   endfunction

   function automatic inverse_type diag_answer(elem_type v, elem_type d, bit sing);
      inverse_type r;
      foreach (r.inv[i]) r.inv[i] = (i % 4 == 0) ? v : '0;
      r.det      = d;
      r.singular = sing;
      return r;
   endfunction

   // random matrix: full-range, small and well-conditioned, or singular
   function automatic matrix_type random_matrix();
      matrix_type m;
      int         kind;
      kind = $urandom_range(0, 9);
      foreach (m.e[i]) begin
         if (kind < 3) m.e[i] = $urandom;
         else          m.e[i] = elem_type'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      end
      if (kind >= 3 && kind < 8)
         for (int i = 0; i < 3; i++) m.e[4 * i] += ($urandom_range(0, 1) ? 4 : -4) * ONE;
      if (kind == 8) begin
         // third row a copy of the first
         for (int c = 0; c < 3; c++) m.e[6 + c] = m.e[c];
      end else if (kind == 9) begin
         // zero column
         for (int r = 0; r < 3; r++) m.e[3 * r + $urandom_range(0, 0)] = '0;
      end
      return m;
   endfunction

   // present one word and hold it until the edge that takes it
   task automatic send_word(matrix_type m);
      int target;
      target = words_accepted + 1;
      start <= 1'b1;
      for (int i = 0; i < NUM_ENTRIES; i++) req_in[i] <= m.e[i];
      do @(negedge clock); while (words_accepted < target);
   endtask

   // each cycle idles with the phase's probability
   task automatic maybe_idle();
      while ($urandom_range(0, 99) < send_gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // accept words and check results at the rising edge
   always @(posedge clock) begin
      inverse_type want, pred;
      matrix_type  seen;
      int          bad;
      cycles <= cycles + 1;
      if (!reset && start && !busy) begin
         for (int i = 0; i < NUM_ENTRIES; i++) seen.e[i] = req_in[i];
         pred = invert_matrix(seen);
         pending_inverses.push_back(pred);
         words_accepted <= words_accepted + 1;
      end
      if (!reset && rsp_valid) begin
         if (pending_inverses.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result word at cycle %0d", cycles);
         end else begin
            want = pending_inverses.pop_front();
            // typed answers from the table override the predictor
            if (typed_flags.size() != 0) begin
               if (typed_flags.pop_front()) want = typed_answers.pop_front();
               else void'(typed_answers.pop_front());
            end
            bad = 0;
            for (int i = 0; i < NUM_ENTRIES; i++) if (rsp_inv[i] !== want.inv[i]) bad++;
            if (rsp_determinant !== want.det) bad++;
            if (rsp_singular !== want.singular) bad++;
            if (bad != 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("mismatch on word %0d:", words_checked);
                  for (int i = 0; i < NUM_ENTRIES; i++)
                     $display("  inv[%0d] expected %h got %h", i, want.inv[i], rsp_inv[i]);
                  $display("  det expected %h got %h, singular expected %b got %b",
                           want.det, rsp_determinant, want.singular, rsp_singular);
               end
            end
            if (want.singular) singular_seen <= singular_seen + 1;
            words_checked <= words_checked + 1;
         end
      end
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   vector_type directed[$];

   initial begin
      vector_type v;
      matrix_type m;
      // identity, zero, rank one, scaled identity: answers obvious
      v.typed = 1;
      v.mat = diag_matrix(ONE);      v.want = diag_answer(ONE, ONE, 0);           directed.push_back(v);
      v.mat = fill_matrix('0);       v.want = diag_answer('0, '0, 1);             directed.push_back(v);
      v.mat = fill_matrix(EMAX);     v.want = diag_answer('0, '0, 1);             directed.push_back(v);
      v.mat = fill_matrix(EMIN);     v.want = diag_answer('0, '0, 1);             directed.push_back(v);
      v.mat = diag_matrix(2 * ONE);  v.want = diag_answer(ONE / 2, 8 * ONE, 0);   directed.push_back(v);
      v.mat = diag_matrix(-ONE);     v.want = diag_answer(-ONE, -ONE, 0);         directed.push_back(v);
      // extremes and saturation, checked against the predictor
      v.typed = 0;
      v.mat = diag_matrix(EMAX);     directed.push_back(v);
      v.mat = diag_matrix(EMIN);     directed.push_back(v);
      v.mat = diag_matrix(1);        directed.push_back(v);   // inverse saturates high
      v.mat = diag_matrix(-1);       directed.push_back(v);   // inverse saturates low
      v.mat = diag_matrix(elem_type'(-1));
      v.mat.e[1] = EMAX;             directed.push_back(v);
      m = diag_matrix(EMIN); m.e[2] = EMAX; m.e[6] = EMIN;
      v.mat = m;                     directed.push_back(v);
      m = fill_matrix(ONE); m.e[4] = 2 * ONE; m.e[8] = 3 * ONE;
      v.mat = m;                     directed.push_back(v);
      m = fill_matrix(EMAX); m.e[0] = EMIN; m.e[4] = EMIN; m.e[8] = EMIN;
      v.mat = m;                     directed.push_back(v);
      m = fill_matrix(elem_type'(32'h5555_5555)); m.e[4] = elem_type'(32'hAAAA_AAAA);
      v.mat = m;                     directed.push_back(v);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[k]) begin
         typed_flags.push_back(directed[k].typed);
         typed_answers.push_back(directed[k].want);
         send_word(directed[k].mat);
      end

      // three idling phases: sparse gaps, heavy gaps, back to back
      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 29 : (phase == 1) ? 73 : 0;
         for (int k = 0; k < N_RANDOM / 3; k++) begin
            maybe_idle();
            send_word(random_matrix());
         end
      end
      start <= 1'b0;

      while (pending_inverses.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);

      $display("covered %0d matrices (%0d singular) with directed extremes and three idle mixes",
               words_checked, singular_seen);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatching words", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
